@@ hw/rtl/srecord_s3_record_encoder_macros.svh @@
// Assertion macros for the S3 record encoder.
// Each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message string.
`ifndef SRECORD_S3_RECORD_ENCODER_MACROS_SVH
`define SRECORD_S3_RECORD_ENCODER_MACROS_SVH

`ifndef SYNTH

`define SREC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SREC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SREC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define SREC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/srec_pkg.sv @@
`timescale 1ns / 1ps

package srec_pkg;

    localparam int RECORD_BYTES_DEFAULT = 16;
    localparam int RECORD_BYTES_MAX     = 24;
    localparam int ADDR_W               = 32;
    localparam int BYTE_W               = 8;
    // Wide enough for any record length up to the maximum.
    localparam int REC_CNT_W            = $clog2(RECORD_BYTES_MAX + 1);

    // Count byte overhead: four address bytes and the checksum byte.
    localparam logic [7:0] COUNT_OVERHEAD = 8'd5;
    // Position of the first data byte in the byte sequence of a record.
    localparam logic [7:0] FIRST_DATA_POS = 8'd5;
    localparam logic [7:0] LAST_ADDR_POS  = 8'd4;

    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_3  = 8'h33;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S,
        ST_3,
        ST_HI,
        ST_LO,
        ST_RAW,
        ST_NL
    } emit_state_t;

    typedef struct packed {
        logic                   start;
        logic [REC_CNT_W-1:0]   count;
        logic [ADDR_W-1:0]      addr;
    } rec_req_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/srec_gather.sv @@
`timescale 1ns / 1ps

module srec_gather
    import srec_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEFAULT,
    localparam int CNT_W = $clog2(RECORD_BYTES + 1),
    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [ADDR_W-1:0]   buffer_address,
    input  logic                last_byte,
    input  logic [IDX_W-1:0]    rd_index,
    output logic [BYTE_W-1:0]   rd_data,
    output rec_req_t            req
);

    logic [BYTE_W-1:0] store_reg [RECORD_BYTES];
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              in_buffer_reg, in_buffer_next;

    logic [CNT_W-1:0]  fill_plus;
    logic [ADDR_W-1:0] base_addr;
    logic              flush;

    assign fill_plus = fill_reg + CNT_W'(1);
    assign base_addr = in_buffer_reg ? addr_reg : buffer_address;
    assign flush     = last_byte || (fill_plus == CNT_W'(RECORD_BYTES));

    always_comb
    begin
        fill_next      = fill_reg;
        addr_next      = addr_reg;
        in_buffer_next = in_buffer_reg;
        req.start      = 1'b0;
        req.count      = REC_CNT_W'(fill_plus);
        req.addr       = base_addr;
        if (accept) begin
            if (flush) begin
                req.start      = 1'b1;
                fill_next      = '0;
                addr_next      = base_addr + ADDR_W'(fill_plus);
                in_buffer_next = !last_byte;
            end else begin
                fill_next      = fill_plus;
                addr_next      = base_addr;
                in_buffer_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg      <= '0;
            addr_reg      <= '0;
            in_buffer_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            addr_reg      <= addr_next;
            in_buffer_reg <= in_buffer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            store_reg[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    always_comb
    begin
        if ({1'b0, rd_index} < (IDX_W + 1)'(RECORD_BYTES)) begin
            rd_data = store_reg[rd_index];
        end else begin
            rd_data = '0;
        end
    end

endmodule

@@ hw/rtl/srec_emit.sv @@
`timescale 1ns / 1ps

module srec_emit
    import srec_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEFAULT,
    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1,
    localparam int BIDX_W = $clog2(RECORD_BYTES + 6)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rec_req_t            req,
    input  logic                raw_mode,
    output logic                idle,
    output logic [IDX_W-1:0]    rd_index,
    input  logic [BYTE_W-1:0]   rd_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                record_end
);

    emit_state_t          state_reg, state_next;
    logic [BIDX_W-1:0]    bidx_reg, bidx_next;
    logic [7:0]           sum_reg, sum_next;
    logic [REC_CNT_W-1:0] n_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg;
    logic                 record_end_reg;

    logic [7:0] bpos, n8, cur_byte, char_val;
    logic       load, end_val, byte_done;
    logic       is_cksum, next_is_data, next_is_cksum;
    logic [BIDX_W-1:0] data_pos;

    assign bpos     = 8'(bidx_reg);
    assign n8       = 8'(n_reg);
    assign data_pos = bidx_reg - BIDX_W'(FIRST_DATA_POS);
    assign rd_index = data_pos[IDX_W-1:0];

    assign is_cksum      = (bpos == n8 + COUNT_OVERHEAD);
    assign next_is_data  = (bpos >= LAST_ADDR_POS) && (bpos < n8 + LAST_ADDR_POS);
    assign next_is_cksum = (bpos + 8'd1 == n8 + COUNT_OVERHEAD);

    always_comb
    begin
        priority if (bpos == 8'd0) begin
            cur_byte = n8 + COUNT_OVERHEAD;
        end else if (bpos <= LAST_ADDR_POS) begin
            cur_byte = 8'(addr_reg >> (6'd32 - {bpos[2:0], 3'd0}));
        end else if (!is_cksum) begin
            cur_byte = rd_data;
        end else begin
            cur_byte = ~sum_reg;
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign load = !idle && (!out_valid_reg || out_ready);

    // Output selection: the character of the current step.
    always_comb
    begin
        char_val  = CHAR_S;
        end_val   = 1'b0;
        byte_done = 1'b0;
        unique case (state_reg)
            ST_IDLE: char_val = CHAR_S;
            ST_S:    char_val = CHAR_S;
            ST_3:    char_val = CHAR_3;
            ST_HI:   char_val = hex_char(cur_byte[7:4]);
            ST_LO:
            begin
                char_val  = hex_char(cur_byte[3:0]);
                byte_done = 1'b1;
            end
            ST_RAW:
            begin
                char_val  = cur_byte;
                byte_done = 1'b1;
            end
            ST_NL:
            begin
                char_val = CHAR_NL;
                end_val  = 1'b1;
            end
            default: char_val = CHAR_S;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req.start) state_next = ST_S;
            ST_S:    if (load) state_next = ST_3;
            ST_3:    if (load) state_next = ST_HI;
            ST_HI:   if (load) state_next = ST_LO;
            ST_LO:
            begin
                if (load) begin
                    priority if (is_cksum) begin
                        state_next = ST_NL;
                    end else if (next_is_data && raw_mode) begin
                        state_next = ST_RAW;
                    end else begin
                        state_next = ST_HI;
                    end
                end
            end
            ST_RAW:
            begin
                if (load) begin
                    state_next = next_is_cksum ? ST_HI : ST_RAW;
                end
            end
            ST_NL:   if (load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        bidx_next = bidx_reg;
        sum_next  = sum_reg;
        if (idle && req.start) begin
            bidx_next = '0;
            sum_next  = '0;
        end else if (load && byte_done) begin
            bidx_next = bidx_reg + BIDX_W'(1);
            sum_next  = sum_reg + cur_byte;
        end
    end

    always_comb
    begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bidx_reg      <= '0;
            sum_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bidx_reg      <= bidx_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (idle && req.start) begin
            n_reg    <= req.count;
            addr_reg <= req.addr;
        end
        if (load) begin
            out_char_reg   <= char_val;
            record_end_reg <= end_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign record_end = record_end_reg;

endmodule

@@ hw/rtl/srecord_s3_record_encoder.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   data_byte, buffer_address, last_byte
// out       output     out_valid / out_ready out_char, record_end
// cfg       input      cfg_valid / cfg_ready cfg_data (raw_data_mode)
//
// A data item that does not close a record is stored and does not block input.
// An item that closes a record keeps in_ready low while the record text is
// produced, one character per cycle while the out channel does not stall,
// with the data bytes in hex in hex mode and as raw bytes in raw mode.
// Reset clears the fill count, the record address and the buffer flag at once.
// A stalled out channel holds the current character and pauses the sequencer.

`include "srecord_s3_record_encoder_macros.svh"

module srecord_s3_record_encoder
    import srec_pkg::*;
#(
    parameter int RECORD_BYTES = RECORD_BYTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [ADDR_W-1:0]   buffer_address,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                record_end,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic              raw_mode_reg, raw_mode_next;
    logic              emit_idle;
    logic              accept;
    logic [IDX_W-1:0]  rd_index;
    logic [BYTE_W-1:0] rd_data;
    rec_req_t          req;

    // The register port never stalls; user writes must come only while idle, unchecked.
    assign cfg_ready     = 1'b1;
    assign raw_mode_next = (cfg_valid && cfg_ready) ? cfg_data : raw_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_mode_reg <= 1'b0;
        end else begin
            raw_mode_reg <= raw_mode_next;
        end
    end

    // Input bytes are taken whenever the sequencer has no record in progress.
    // A finished character may still wait in the output register meanwhile.
    assign in_ready = emit_idle;
    assign accept   = in_valid && in_ready;

    // The gather stage stores the bytes of the current group and tracks the
    // record address; it raises a request when the group fills or the buffer ends.
    srec_gather #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_gather (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .buffer_address (buffer_address),
        .last_byte      (last_byte),
        .rd_index       (rd_index),
        .rd_data        (rd_data),
        .req            (req)
    );

    // The emitter walks the record byte by byte through one shared byte selector
    // and checksum adder, one character per cycle while the out channel does not stall.
    srec_emit #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .raw_mode   (raw_mode_reg),
        .idle       (emit_idle),
        .rd_index   (rd_index),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .record_end (record_end)
    );

    // A flushing item must start the sequencer, which then blocks input.
    `SREC_ASSERT_NXT(a_flush_blocks, clk, rst_n, req.start, !in_ready, "flush did not start record")
    // The record end mark only ever travels with the closing newline.
    `SREC_ASSERT_IMP(a_end_is_nl, clk, rst_n, out_valid && record_end, out_char == CHAR_NL, "record end without newline")
    // A request is only raised for an accepted item.
    `SREC_ASSERT_IMP(a_req_on_accept, clk, rst_n, req.start, in_valid && in_ready, "request without accepted item")

endmodule
